@@ design/epd_pkg.sv @@
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types and constants for the emitter pair phase driver.
// ----------------------------------------------------------------------------
package epd_pkg;

  // Default sizing of the emitter array and the phase wheel
  localparam int PAIR_COUNT_DEF  = 64;
  localparam int PHASE_STEPS_DEF = 1000;

  // Configuration register indexes
  localparam int                   CFG_ADDR_W       = 1;
  localparam int                   CFG_DATA_W       = 10;
  localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_CAP     = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SENSOR_LIMIT = 1'd1;

  // Register reset values
  localparam logic [7:0] DUTY_CAP_RST     = 8'd80;
  localparam logic [9:0] SENSOR_LIMIT_RST = 10'd900;

  // Coherence filter: c' = (7*c + s) / 8
  localparam logic [12:0] FILTER_OLD_WEIGHT = 13'd7;
  localparam int          FILTER_SHIFT      = 3;

  // Duty: 20 + c/20; c/20 = (c>>2)/5 = ((c>>2)*205)>>10, exact for c>>2 < 256
  localparam logic [7:0]  DUTY_BASE       = 8'd20;
  localparam logic [15:0] DUTY_DIV5_MUL   = 16'd205;
  localparam int          DUTY_DIV5_SHIFT = 10;

  // Stream payload widths (bytes rounded up)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic       door_closed;
    logic       over_temperature;
    logic       over_current;
    logic [9:0] center_sample;
  } epd_item_t;

  typedef struct packed {
    logic       failsafe_on;
    logic [5:0] upper_emitter;
    logic [6:0] lower_emitter;
    logic [7:0] drive_duty;
    logic [9:0] phase_now;
    logic [9:0] coherence_now;
  } epd_result_t;

endpackage

@@ design/epd_in_reg.sv @@
// ----------------------------------------------------------------------------
// epd_in_reg
// Input register stage: captures one tick transaction per cycle while dn_ready is high.
// ----------------------------------------------------------------------------
module epd_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  epd_pkg::epd_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output epd_pkg::epd_item_t dn_item
);
  import epd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  epd_item_t item_r;

  // Accept when empty or when the held item moves on this cycle
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

@@ design/epd_step_calc.sv @@
// ----------------------------------------------------------------------------
// epd_step_calc
// Tick datapath: interlock check, phase and pair index advance, coherence
// filter and duty.
// ----------------------------------------------------------------------------
module epd_step_calc #(
  parameter int PAIR_COUNT  = epd_pkg::PAIR_COUNT_DEF,
  parameter int PHASE_STEPS = epd_pkg::PHASE_STEPS_DEF,
  parameter int PAIR_W      = $clog2(PAIR_COUNT),
  parameter int PHASE_W     = $clog2(PHASE_STEPS)
) (
  input  epd_pkg::epd_item_t   item,
  input  logic [7:0]           duty_cap,
  input  logic [9:0]           sensor_limit,
  input  logic [PHASE_W-1:0]   phase,
  input  logic [PAIR_W-1:0]    pair_idx,
  input  logic [PHASE_W-1:0]   pair_rem,
  input  logic [9:0]           coh,
  output logic [PHASE_W-1:0]   phase_adv,
  output logic [PAIR_W-1:0]    pair_idx_adv,
  output logic [PHASE_W-1:0]   pair_rem_adv,
  output logic [9:0]           coh_adv,
  output epd_pkg::epd_result_t result
);
  import epd_pkg::*;

  // Pair index tracks phase*PAIR_COUNT/PHASE_STEPS as quotient and remainder
  localparam int QW        = PAIR_W + 1;
  localparam int RW        = PHASE_W + 1;
  localparam int PAIR_QUOT = PAIR_COUNT / PHASE_STEPS;
  localparam int PAIR_REM  = PAIR_COUNT % PHASE_STEPS;

  logic              hold;
  logic              wrap;
  logic [RW-1:0]     rem_sum;
  logic              carry;
  logic [QW-1:0]     quot_sum;
  logic [QW-1:0]     upper_q;
  logic [QW-1:0]     lower_q;
  logic [12:0]       filt_sum;
  logic [7:0]        coh_quarter;
  logic [15:0]       div5_prod;
  logic [7:0]        duty_raw;
  logic [7:0]        duty;
  logic [31:0]       upper_ext;
  logic [31:0]       lower_ext;
  logic [31:0]       phase_ext;
  logic [31:0]       phase_hold_ext;

  assign hold = !item.door_closed || item.over_temperature || item.over_current
                || (item.center_sample > sensor_limit);

  assign wrap     = (32'(phase) == PHASE_STEPS - 1);
  assign rem_sum  = RW'(pair_rem) + RW'(PAIR_REM);
  assign carry    = (32'(rem_sum) >= PHASE_STEPS);
  assign quot_sum = QW'(pair_idx) + QW'(PAIR_QUOT) + QW'(carry);

  always_comb begin
    if (wrap) begin
      phase_adv    = '0;
      pair_idx_adv = '0;
      pair_rem_adv = '0;
    end else begin
      phase_adv    = phase + PHASE_W'(1);
      pair_rem_adv = carry ? PHASE_W'(32'(rem_sum) - PHASE_STEPS) : rem_sum[PHASE_W-1:0];
      // saturate at the top pair
      pair_idx_adv = (32'(quot_sum) >= PAIR_COUNT) ? PAIR_W'(PAIR_COUNT - 1)
                                                   : quot_sum[PAIR_W-1:0];
    end
  end

  // Filter only on a nonzero sample
  assign filt_sum = 13'(coh) * FILTER_OLD_WEIGHT + 13'(item.center_sample);
  assign coh_adv  = (item.center_sample != 10'd0) ? filt_sum[FILTER_SHIFT +: 10] : coh;

  assign coh_quarter = coh_adv[9:2];
  assign div5_prod   = 16'(coh_quarter) * DUTY_DIV5_MUL;
  assign duty_raw    = DUTY_BASE + 8'(div5_prod[15:DUTY_DIV5_SHIFT]);
  assign duty        = (duty_raw > duty_cap) ? duty_cap : duty_raw;

  assign upper_q        = QW'(pair_idx_adv);
  assign lower_q        = QW'(2 * PAIR_COUNT - 1) - upper_q;
  assign upper_ext      = 32'(upper_q);
  assign lower_ext      = 32'(lower_q);
  assign phase_ext      = 32'(phase_adv);
  assign phase_hold_ext = 32'(phase);

  always_comb begin
    if (hold) begin
      result.failsafe_on   = 1'b1;
      result.upper_emitter = '0;
      result.lower_emitter = '0;
      result.drive_duty    = '0;
      result.phase_now     = phase_hold_ext[9:0];
      result.coherence_now = coh;
    end else begin
      result.failsafe_on   = 1'b0;
      result.upper_emitter = upper_ext[5:0];
      result.lower_emitter = lower_ext[6:0];
      result.drive_duty    = duty;
      result.phase_now     = phase_ext[9:0];
      result.coherence_now = coh_adv;
    end
  end

endmodule

@@ design/epd_out_reg.sv @@
// ----------------------------------------------------------------------------
// epd_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module epd_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  epd_pkg::epd_result_t up_result,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output epd_pkg::epd_result_t dn_result
);
  import epd_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  epd_result_t result_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result_r <= up_result;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_result = result_r;

endmodule

@@ design/emitter_pair_phase_driver_core.sv @@
// ----------------------------------------------------------------------------
// emitter_pair_phase_driver_core
// Per-tick interlock check, phase wheel and emitter pair selection with a
// filtered coherence estimate setting the drive duty.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+--------------------------
//   in_*      | sink      | in_tvalid / in_tready  | in_tdata[15:0]  tick
//   out_*     | source    | out_tvalid / out_tready| out_tdata[47:0] result
//   cfg_*     | sink      | cfg_wr_en              | cfg_addr, cfg_wdata
//
// Rate: one tick transaction per clock while out_tready stays high; an accepted
//   tick passes the input register, then the result register, to out_tvalid.
// The datapath between them is one pass: a compare for the interlocks, an
//   increment with one compare-subtract for the pair index, and a constant
//   multiply for the duty; phase and coherence move with the result unless held.
// Reset: synchronous, active low; phase, pair index and coherence go to zero,
//   duty_cap to 80 and sensor_limit to 900.
// Stalls: out_tready low holds the result register; the input register keeps
//   accepting until it is full too, then in_tready drops.
// ----------------------------------------------------------------------------
module emitter_pair_phase_driver_core #(
  parameter int PAIR_COUNT  = epd_pkg::PAIR_COUNT_DEF,
  parameter int PHASE_STEPS = epd_pkg::PHASE_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // [0] door_closed, [1] over_temperature, [2] over_current,
  // [12:3] center_sample, [15:13] zero
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [epd_pkg::IN_TDATA_W-1:0]        in_tdata,
  // [0] failsafe_on, [6:1] upper_emitter, [13:7] lower_emitter,
  // [21:14] drive_duty, [31:22] phase_now, [41:32] coherence_now, [47:42] zero
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [epd_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [epd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [epd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import epd_pkg::*;

  localparam int PAIR_W  = $clog2(PAIR_COUNT);
  localparam int PHASE_W = $clog2(PHASE_STEPS);

  // Configuration registers
  logic [7:0] duty_cap_r;
  logic [9:0] sensor_limit_r;

  // Tick state
  logic [PHASE_W-1:0] phase_r;
  logic [PAIR_W-1:0]  pair_idx_r;
  logic [PHASE_W-1:0] pair_rem_r;
  logic [9:0]         coh_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [PAIR_W-1:0]  pair_idx_nxt;
  logic [PHASE_W-1:0] pair_rem_nxt;
  logic [9:0]         coh_nxt;

  // Datapath results for the held tick
  logic [PHASE_W-1:0] phase_adv;
  logic [PAIR_W-1:0]  pair_idx_adv;
  logic [PHASE_W-1:0] pair_rem_adv;
  logic [9:0]         coh_adv;

  epd_item_t   in_item;
  epd_item_t   s1_item;
  logic        s1_valid;
  logic        s1_ready;
  logic        s1_fire;
  epd_result_t s1_result;
  epd_result_t out_result;

  // Unpack the tick transaction, first field in the low bits
  assign in_item.door_closed      = in_tdata[0];
  assign in_item.over_temperature = in_tdata[1];
  assign in_item.over_current     = in_tdata[2];
  assign in_item.center_sample    = in_tdata[12:3];

  // Write a configuration register; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_cap_r     <= DUTY_CAP_RST;
      sensor_limit_r <= SENSOR_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_DUTY_CAP:     duty_cap_r     <= cfg_wdata[7:0];
        CFG_SENSOR_LIMIT: sensor_limit_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  epd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_item  (in_item),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_item  (s1_item)
  );

  epd_step_calc #(
    .PAIR_COUNT  (PAIR_COUNT),
    .PHASE_STEPS (PHASE_STEPS),
    .PAIR_W      (PAIR_W),
    .PHASE_W     (PHASE_W)
  ) u_step_calc (
    .item         (s1_item),
    .duty_cap     (duty_cap_r),
    .sensor_limit (sensor_limit_r),
    .phase        (phase_r),
    .pair_idx     (pair_idx_r),
    .pair_rem     (pair_rem_r),
    .coh          (coh_r),
    .phase_adv    (phase_adv),
    .pair_idx_adv (pair_idx_adv),
    .pair_rem_adv (pair_rem_adv),
    .coh_adv      (coh_adv),
    .result       (s1_result)
  );

  // Advance state only when the tick moves into the result register and the
  // interlocks allow it; a held-safe tick leaves phase and coherence alone.
  assign s1_fire = s1_valid && s1_ready;

  always_comb begin
    phase_nxt    = phase_r;
    pair_idx_nxt = pair_idx_r;
    pair_rem_nxt = pair_rem_r;
    coh_nxt      = coh_r;
    if (s1_fire && !s1_result.failsafe_on) begin
      phase_nxt    = phase_adv;
      pair_idx_nxt = pair_idx_adv;
      pair_rem_nxt = pair_rem_adv;
      coh_nxt      = coh_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      pair_idx_r <= '0;
      pair_rem_r <= '0;
      coh_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pair_idx_r <= pair_idx_nxt;
      pair_rem_r <= pair_rem_nxt;
      coh_r      <= coh_nxt;
    end
  end

  epd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s1_valid),
    .up_ready  (s1_ready),
    .up_result (s1_result),
    .dn_valid  (out_tvalid),
    .dn_ready  (out_tready),
    .dn_result (out_result)
  );

  // Pack the result transaction, first field in the low bits
  assign out_tdata = {6'd0,
                      out_result.coherence_now,
                      out_result.phase_now,
                      out_result.drive_duty,
                      out_result.lower_emitter,
                      out_result.upper_emitter,
                      out_result.failsafe_on};

`ifndef ASSERT_OFF
  // Phase wheel stays inside its step count
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(phase_r) < PHASE_STEPS)
    else $error("phase counter out of range");

  // Pair index stays a valid upper-bank emitter
  a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pair_idx_r) < PAIR_COUNT)
    else $error("pair index out of range");

  // A safe-hold result lights nothing
  a_hold_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_result.failsafe_on) |->
      (out_result.drive_duty == 8'd0 && out_result.upper_emitter == 6'd0
       && out_result.lower_emitter == 7'd0))
    else $error("emitter driven during safe hold");

  // Driven duty never exceeds the cap
  a_duty_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_result.failsafe_on) |-> (s1_result.drive_duty <= duty_cap_r))
    else $error("duty above cap");

  // State moves only with a transaction that passes the interlocks
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_fire && !s1_result.failsafe_on) |=> ($stable(phase_r) && $stable(coh_r)))
    else $error("tick state changed without a driven transaction");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for emitter_pair_phase_driver_core. A short table of
// directed ticks (interlock faults, sensor limit edges, zero sample) is walked
// first, then five random run plans follow, each with its own duty cap,
// sensor limit and idling mix. A local predictor tracks phase and coherence
// and every result transaction is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

  import epd_pkg::*;

  localparam int PAIRS = epd_pkg::PAIR_COUNT_DEF;
  localparam int STEPS = epd_pkg::PHASE_STEPS_DEF;

  // Coherence filter and duty law of the block
  localparam int unsigned COH_KEEP   = 7;
  localparam int unsigned COH_SHIFT  = 3;
  localparam int unsigned DUTY_FLOOR = 20;
  localparam int unsigned DUTY_STEP  = 20;

  localparam int MAX_REPORTS = 10;

  logic                               clk;
  logic                               rst_n;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [epd_pkg::IN_TDATA_W-1:0]     in_tdata;
  logic                               out_tvalid;
  logic                               out_tready;
  logic [epd_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                               cfg_wr_en;
  logic [epd_pkg::CFG_ADDR_W-1:0]     cfg_addr;
  logic [epd_pkg::CFG_DATA_W-1:0]     cfg_wdata;

  emitter_pair_phase_driver_core #(
    .PAIR_COUNT (PAIRS),
    .PHASE_STEPS(STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the block's state and registers
  int unsigned phase_q;
  int unsigned coh_q;
  int unsigned cap_q;
  int unsigned limit_q;

  // Results owed by the block, oldest first
  epd_result_t expected_drive_q[$];

  // Run statistics
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned holds_seen;
  int unsigned phase_wraps;
  int unsigned coh_peak;
  int unsigned mismatch_cnt;

  // Idling knobs: idle and stall chances in percent per cycle, hold-off in cycles
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_holdoff_req;

  typedef struct {
    epd_item_t   tick;
    bit          typed;
    epd_result_t want;
  } dir_row_t;

  typedef struct {
    logic [9:0]  cap_word;
    logic [9:0]  limit_word;
    int unsigned tx_pct;
    int unsigned rx_pct;
    int unsigned n_ticks;
    bit          bias_hi;
    bit          pressure;
  } run_plan_t;

  dir_row_t dir_rows[$];

  // Cap words with bits above [7:0] set check that the block drops them.
  run_plan_t plans[5] = '{
    '{10'd80,  10'd900,  0,  0,  300, 1'b0, 1'b0},
    '{10'h0FF, 10'd1023, 53, 0,  300, 1'b1, 1'b0},
    '{10'h300, 10'd0,    0,  53, 250, 1'b0, 1'b0},
    '{10'd45,  10'd700,  25, 25, 400, 1'b0, 1'b1},
    '{10'h350, 10'd1023, 0,  0,  700, 1'b1, 1'b0}
  };

  // ------------------------------------------------------------------------
  // Predictor: one tick in, one result out, state advanced in place
  // ------------------------------------------------------------------------
  function automatic epd_result_t predict_emitter_pair(input epd_item_t t);
    epd_result_t r;
    bit          hold;
    int unsigned idx;
    int unsigned duty;
    r    = '0;
    hold = !t.door_closed || t.over_temperature || t.over_current ||
           (t.center_sample > limit_q);
    if (!hold) begin
      if (phase_q == STEPS - 1) begin
        phase_q = 0;
        phase_wraps++;
      end else begin
        phase_q++;
      end
      // A zero sample leaves the estimate alone
      if (t.center_sample != 0)
        coh_q = ((coh_q * COH_KEEP + t.center_sample) >> COH_SHIFT) & 10'h3FF;
      idx = (phase_q * PAIRS) / STEPS;
      if (idx >= PAIRS)
        idx = PAIRS - 1;
      duty = DUTY_FLOOR + coh_q / DUTY_STEP;
      if (duty > cap_q)
        duty = cap_q;
      r.upper_emitter = 6'(idx);
      r.lower_emitter = 7'(2 * PAIRS - 1 - idx);
      r.drive_duty    = 8'(duty);
    end
    if (coh_q > coh_peak)
      coh_peak = coh_q;
    r.failsafe_on   = hold;
    r.phase_now     = 10'(phase_q);
    r.coherence_now = 10'(coh_q);
    return r;
  endfunction

  function automatic logic [epd_pkg::IN_TDATA_W-1:0] pack_tick(input epd_item_t t);
    return {3'b000, t.center_sample, t.over_current, t.over_temperature,
            t.door_closed};
  endfunction

  function automatic epd_result_t unpack_result(
    input logic [epd_pkg::OUT_TDATA_W-1:0] d
  );
    epd_result_t r;
    r.failsafe_on   = d[0];
    r.upper_emitter = d[6:1];
    r.lower_emitter = d[13:7];
    r.drive_duty    = d[21:14];
    r.phase_now     = d[31:22];
    r.coherence_now = d[41:32];
    return r;
  endfunction

  function automatic epd_item_t mk_tick(input bit closed, input bit hot,
                                        input bit overcur, input logic [9:0] sample);
    epd_item_t t;
    t.door_closed      = closed;
    t.over_temperature = hot;
    t.over_current     = overcur;
    t.center_sample    = sample;
    return t;
  endfunction

  function automatic epd_result_t mk_res(input bit hold, input int unsigned up,
                                         input int unsigned lo, input int unsigned duty,
                                         input int unsigned ph, input int unsigned coh);
    epd_result_t r;
    r.failsafe_on   = hold;
    r.upper_emitter = 6'(up);
    r.lower_emitter = 7'(lo);
    r.drive_duty    = 8'(duty);
    r.phase_now     = 10'(ph);
    r.coherence_now = 10'(coh);
    return r;
  endfunction

  function automatic void add_row(input epd_item_t t, input bit typed,
                                  input epd_result_t want);
    dir_row_t row;
    row.tick  = t;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Mostly clean ticks with samples around the limit; the rest carry random
  // interlock flags so every fault combination shows up.
  function automatic epd_item_t draw_tick(input bit bias_hi);
    epd_item_t   t;
    int unsigned pick;
    t    = mk_tick(1'b1, 1'b0, 1'b0, 10'd0);
    pick = $urandom_range(9);
    case (pick)
      0: begin
        t.center_sample = 10'd0;
      end
      1: begin
        t.center_sample = 10'(limit_q);
      end
      2: begin
        t.center_sample = 10'h3FF;
      end
      3: begin
        t.center_sample = (limit_q == 1023) ? 10'h3FF : 10'(limit_q + 1);
      end
      4: begin
        t.center_sample = 10'($urandom_range(1023));
      end
      default: begin
        if (bias_hi)
          t.center_sample = 10'($urandom_range(limit_q, limit_q - limit_q / 8));
        else
          t.center_sample = 10'($urandom_range(limit_q));
      end
    endcase
    if ($urandom_range(99) < 22) begin
      t.door_closed      = 1'($urandom_range(1));
      t.over_temperature = 1'($urandom_range(1));
      t.over_current     = 1'($urandom_range(1));
    end
    return t;
  endfunction

  // ------------------------------------------------------------------------
  // Input side: optional idle gap, then offer the tick until it is taken
  // ------------------------------------------------------------------------
  task automatic send_tick(input epd_item_t t, input bit typed,
                           input epd_result_t want);
    epd_result_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_tick(t);
    do @(posedge clk); while (!in_tready);
    // Advance the predictor even when the row carries a typed expectation
    p = predict_emitter_pair(t);
    expected_drive_q.push_back(typed ? want : p);
    ticks_sent++;
  endtask

  // Stop offering and let every owed result come back
  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (expected_drive_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; the block must be idle
  task automatic load_regs(input logic [9:0] cap_word, input logic [9:0] limit_word);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= epd_pkg::CFG_DUTY_CAP;
    cfg_wdata <= cap_word;
    @(posedge clk);
    cap_q     = 32'(cap_word[7:0]);
    cfg_addr  <= epd_pkg::CFG_SENSOR_LIMIT;
    cfg_wdata <= limit_word;
    @(posedge clk);
    limit_q   = 32'(limit_word);
    cfg_wr_en <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Clock and run limit
  // ------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout: %0d results still owed", expected_drive_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off when one is requested.
  // The hold-off is counted here so the sender keeps pushing meanwhile and
  // the block has to back up into in_tready.
  // ------------------------------------------------------------------------
  initial begin : out_ready_gen
    int unsigned hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_holdoff_req != 0) begin
        hold_left      = rx_holdoff_req;
        rx_holdoff_req = 0;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result check: compare each result transaction with the oldest expectation
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    epd_result_t got;
    epd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = unpack_result(out_tdata);
      results_seen++;
      if (got.failsafe_on)
        holds_seen++;
      if (expected_drive_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: result with nothing owed: %h", $realtime, out_tdata);
      end else begin
        want = expected_drive_q.pop_front();
        if (got.failsafe_on   !== want.failsafe_on   ||
            got.upper_emitter !== want.upper_emitter ||
            got.lower_emitter !== want.lower_emitter ||
            got.drive_duty    !== want.drive_duty    ||
            got.phase_now     !== want.phase_now     ||
            got.coherence_now !== want.coherence_now) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: result %0d mismatch", $realtime, results_seen);
            $display("  exp hold=%0d up=%0d lo=%0d duty=%0d phase=%0d coh=%0d",
                     want.failsafe_on, want.upper_emitter, want.lower_emitter,
                     want.drive_duty, want.phase_now, want.coherence_now);
            $display("  got hold=%0d up=%0d lo=%0d duty=%0d phase=%0d coh=%0d",
                     got.failsafe_on, got.upper_emitter, got.lower_emitter,
                     got.drive_duty, got.phase_now, got.coherence_now);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_addr       <= '0;
    cfg_wdata      <= '0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_holdoff_req = 0;
    ticks_sent     = 0;
    results_seen   = 0;
    holds_seen     = 0;
    phase_wraps    = 0;
    coh_peak       = 0;
    mismatch_cnt   = 0;

    // Reset values of state and registers
    phase_q = 0;
    coh_q   = 0;
    cap_q   = 32'(epd_pkg::DUTY_CAP_RST);
    limit_q = 32'(epd_pkg::SENSOR_LIMIT_RST);

    // Directed ticks against reset registers (cap 80, limit 900).
    // Typed rows: every fault flag alone and together, sample just above the
    // limit, a zero sample that still advances the phase, sample at the limit.
    add_row(mk_tick(1'b0, 1'b0, 1'b0, 10'd0),    1'b1, mk_res(1, 0, 0,   0,  0, 0));
    add_row(mk_tick(1'b1, 1'b1, 1'b0, 10'd300),  1'b1, mk_res(1, 0, 0,   0,  0, 0));
    add_row(mk_tick(1'b1, 1'b0, 1'b1, 10'd1023), 1'b1, mk_res(1, 0, 0,   0,  0, 0));
    add_row(mk_tick(1'b0, 1'b1, 1'b1, 10'd1023), 1'b1, mk_res(1, 0, 0,   0,  0, 0));
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'd1023), 1'b1, mk_res(1, 0, 0,   0,  0, 0));
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'd0),    1'b1, mk_res(0, 0, 127, 20, 1, 0));
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'd900),  1'b1, mk_res(0, 0, 127, 25, 2, 112));
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'd901),  1'b1, mk_res(1, 0, 0,   0,  2, 112));
    // Predicted rows: smallest sample, alternating bit patterns, near limit, faults, mid-range, zero
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'd1),    1'b0, '0);
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'h2AA),  1'b0, '0);
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'h155),  1'b0, '0);
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'd899),  1'b0, '0);
    add_row(mk_tick(1'b0, 1'b0, 1'b0, 10'd1),    1'b0, '0);
    add_row(mk_tick(1'b1, 1'b1, 1'b1, 10'd0),    1'b0, '0);
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'd512),  1'b0, '0);
    add_row(mk_tick(1'b1, 1'b0, 1'b0, 10'd0),    1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);

    // Random plans: drain, reprogram, set the idling mix, then stream
    foreach (plans[p]) begin
      drain_results();
      load_regs(plans[p].cap_word, plans[p].limit_word);
      tx_idle_pct  = plans[p].tx_pct;
      rx_stall_pct = plans[p].rx_pct;
      for (int i = 0; i < plans[p].n_ticks; i++) begin
        if (plans[p].pressure && i == 100)
          rx_holdoff_req = 96;
        // Pause the sender until the block has handed back everything
        if (plans[p].pressure && i == 220)
          drain_results();
        send_tick(draw_tick(plans[p].bias_hi), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("run: %0d ticks, %0d results (%0d safe holds), %0d phase wraps",
             ticks_sent, results_seen, holds_seen, phase_wraps);
    $display("     duty cap 0..255, sensor limit 0..1023, coherence peak %0d, %0d mismatches",
             coh_peak, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
